// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property that must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/core/bsc_pkg.sv =====
// Shared types, codes and constants of the banker's safety checker.
package bsc_pkg;

  localparam int DEF_CLIENTS     = 8;
  localparam int DEF_RESOURCES   = 4;
  localparam int DEF_AMOUNT_BITS = 8;

  localparam int MAX_RESULTS = 8;
  localparam int WORK_BITS   = 12;
  localparam int WORK_MAX    = 4095;

  localparam int NUM_AVAIL  = 4;
  localparam int AVAIL_W    = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int CLIENT_W    = 4;
  localparam int AMT_IN_W    = 8;
  localparam int SEQ_W       = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD_MAX = 2'd0,
    FUNC_REQUEST  = 2'd1,
    FUNC_RELEASE  = 2'd2,
    FUNC_RUN      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CLIENT = 2'd1,
    ST_NO_RELEASE = 2'd2,
    ST_UNSAFE     = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec_op;
    logic run_init;
    logic scan;
    logic push_single;
    logic push_safe;
    logic push_unsafe;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_run;
    logic out_free;
    logic pass_end;
    logic all_done;
    logic progress;
    logic emit_last;
  } sts_t;

endpackage

// ===== rtl/core/bsc_regs.sv =====
// APB register file holding the initially available resource units.
module bsc_regs
  import bsc_pkg::*;
(
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [CFG_ADDR_W-1:0]             paddr,
  input  logic [CFG_DATA_W-1:0]             pwdata,
  output logic [CFG_DATA_W-1:0]             prdata,
  output logic                              pready,
  output logic [NUM_AVAIL-1:0][AVAIL_W-1:0] avail_o
);

  logic [NUM_AVAIL-1:0][AVAIL_W-1:0] avail_q;
  logic [1:0]                        reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign prdata  = CFG_DATA_W'(avail_q[reg_idx]);
  assign avail_o = avail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      avail_q[reg_idx] <= pwdata[AVAIL_W-1:0];
    end
  end

endmodule

// ===== rtl/core/bsc_ctrl.sv =====
// Controller state machine sequencing table updates, the safety scan and result emission.
module bsc_ctrl
  import bsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SAFE,
    S_UNSAFE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_run) begin
          cmd_o.run_init = 1'b1;
          state_d        = S_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.exec_op     = 1'b1;
          cmd_o.push_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.pass_end) begin
          if (sts_i.all_done) begin
            state_d = S_SAFE;
          end else if (!sts_i.progress) begin
            state_d = S_UNSAFE;
          end
        end
      end
      S_SAFE: begin
        if (sts_i.out_free) begin
          cmd_o.push_safe = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_UNSAFE: begin
        if (sts_i.out_free) begin
          cmd_o.push_unsafe = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/bsc_dp.sv =====
// Datapath: claim and allocation tables, working vector, scan state and output register.
module bsc_dp
  import bsc_pkg::*;
#(
  parameter int CLIENTS     = DEF_CLIENTS,
  parameter int RESOURCES   = DEF_RESOURCES,
  parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmd_t                              cmd_i,
  output sts_t                              sts_o,
  input  logic [IN_TUSER_W-1:0]             in_func_i,
  input  logic [CLIENT_W-1:0]               in_client_i,
  input  logic [NUM_AVAIL-1:0][AMT_IN_W-1:0] in_amt_i,
  input  logic [NUM_AVAIL-1:0][AVAIL_W-1:0] avail_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output status_e                           out_status_o,
  output logic [SEQ_W-1:0]                  out_seq_o,
  output logic                              out_last_o
);

  localparam int CW     = $clog2(CLIENTS);
  localparam int CNTW   = $clog2(CLIENTS + 1);
  localparam int AW     = AMOUNT_BITS;
  localparam int SUMW   = ((AW > WORK_BITS) ? AW : WORK_BITS) + 1;
  localparam int EMIT_N = (CLIENTS < MAX_RESULTS) ? CLIENTS : MAX_RESULTS;
  localparam int EW     = $clog2(EMIT_N);

  // Latched input item.
  func_e                          func_q;
  logic [CLIENT_W-1:0]            client_q;
  logic [RESOURCES-1:0][AW-1:0]   amt_q;

  // Per-client rows.
  logic [CLIENTS-1:0][RESOURCES-1:0][AW-1:0] max_q;
  logic [CLIENTS-1:0][RESOURCES-1:0][AW-1:0] alloc_q;

  // Scan state.
  logic [RESOURCES-1:0][WORK_BITS-1:0] work_q;
  logic [CLIENTS-1:0]                  fin_q;
  logic [CNTW-1:0]                     cnt_q;
  logic [CW-1:0]                       idx_q;
  logic                                prog_q;
  logic [CLIENTS-1:0][CW-1:0]          order_q;
  logic [EW-1:0]                       eptr_q;

  // Output register.
  logic              out_valid_q;
  status_e           out_status_q;
  logic [SEQ_W-1:0]  out_seq_q;
  logic              out_last_q;

  logic                                client_ok;
  logic [CW-1:0]                       cidx;
  logic                                rel_bad;
  status_e                             op_status;
  logic [RESOURCES-1:0][SUMW-1:0]      sum;
  logic [RESOURCES-1:0][WORK_BITS-1:0] sat;
  logic                                fits;
  logic                                take;
  logic [CNTW-1:0]                     cnt_nxt;
  logic                                pass_end;
  logic                                out_free;

  assign client_ok = (5'(client_q) < 5'(CLIENTS));
  assign cidx      = client_q[CW-1:0];

  always_comb begin
    rel_bad = 1'b0;
    for (int r = 0; r < RESOURCES; r++) begin
      if (amt_q[r] > alloc_q[cidx][r]) begin
        rel_bad = 1'b1;
      end
    end
  end

  always_comb begin
    if (!client_ok) begin
      op_status = ST_BAD_CLIENT;
    end else if (func_q == FUNC_RELEASE && rel_bad) begin
      op_status = ST_NO_RELEASE;
    end else begin
      op_status = ST_OK;
    end
  end

  // A client fits when max <= work + alloc for every resource, which is the
  // need test without a signed subtract; the same sum feeds the update.
  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      sum[r] = SUMW'(work_q[r]) + SUMW'(alloc_q[idx_q][r]);
      sat[r] = (sum[r] > SUMW'(WORK_MAX)) ? WORK_BITS'(WORK_MAX) : sum[r][WORK_BITS-1:0];
      if (SUMW'(max_q[idx_q][r]) > sum[r]) begin
        fits = 1'b0;
      end
    end
  end

  assign take     = !fin_q[idx_q] && fits;
  assign cnt_nxt  = cnt_q + CNTW'(take);
  assign pass_end = (idx_q == CW'(CLIENTS - 1));
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.is_run    = (func_q == FUNC_RUN);
  assign sts_o.out_free  = out_free;
  assign sts_o.pass_end  = pass_end;
  assign sts_o.all_done  = (cnt_nxt == CNTW'(CLIENTS));
  assign sts_o.progress  = prog_q || take;
  assign sts_o.emit_last = (eptr_q == EW'(EMIT_N - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_e'(in_func_i);
      client_q <= in_client_i;
      for (int r = 0; r < RESOURCES; r++) begin
        amt_q[r] <= AW'(in_amt_i[r]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '0;
      alloc_q <= '0;
    end else if (cmd_i.exec_op && client_ok) begin
      case (func_q)
        FUNC_LOAD_MAX: max_q[cidx] <= amt_q;
        FUNC_REQUEST:  alloc_q[cidx] <= amt_q;
        FUNC_RELEASE: begin
          if (!rel_bad) begin
            for (int r = 0; r < RESOURCES; r++) begin
              alloc_q[cidx][r] <= alloc_q[cidx][r] - amt_q[r];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      fin_q  <= '0;
      cnt_q  <= '0;
      idx_q  <= '0;
      prog_q <= 1'b0;
      eptr_q <= '0;
    end else begin
      if (cmd_i.run_init) begin
        for (int r = 0; r < RESOURCES; r++) begin
          work_q[r] <= WORK_BITS'(avail_i[r]);
        end
        fin_q  <= '0;
        cnt_q  <= '0;
        idx_q  <= '0;
        prog_q <= 1'b0;
        eptr_q <= '0;
      end else if (cmd_i.scan) begin
        if (take) begin
          work_q        <= sat;
          fin_q[idx_q]  <= 1'b1;
          cnt_q         <= cnt_nxt;
        end
        // Each pass restarts from client zero with a fresh progress flag.
        if (pass_end) begin
          idx_q  <= '0;
          prog_q <= 1'b0;
        end else begin
          idx_q  <= idx_q + CW'(1);
          prog_q <= prog_q || take;
        end
      end else if (cmd_i.push_safe) begin
        eptr_q <= eptr_q + EW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && take) begin
      order_q[cnt_q[CW-1:0]] <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_single || cmd_i.push_safe || cmd_i.push_unsafe) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_single) begin
      out_status_q <= op_status;
      out_seq_q    <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.push_safe) begin
      out_status_q <= ST_OK;
      out_seq_q    <= SEQ_W'(order_q[CW'(eptr_q)]);
      out_last_q   <= (eptr_q == EW'(EMIT_N - 1));
    end else if (cmd_i.push_unsafe) begin
      out_status_q <= ST_UNSAFE;
      out_seq_q    <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_seq_o    = out_seq_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== rtl/core/bankers_safety_checker_top.sv =====
// Top level of the banker's algorithm safety checker.
//
//  Channel   Dir  Payload                                         Handshake
//  s_axis    in   tuser: func; tdata: client, amount_0..3         tvalid/tready
//  m_axis    out  tuser: status; tdata: seq_client; tlast: last   tvalid/tready
//  apb       in   avail_0..3 at byte addresses 0, 4, 8, 12        psel/penable
//
// Load, request and release requests put their one result in the output register
// from the decode state. A run loads the working vector from avail_0..3, then
// checks one row per cycle, client by client, for at most CLIENTS passes, then
// sends its results one at a time. The row check (compare and saturating add
// over all resources) sets that pace. A stalled output holds its result; the
// input is taken again once the last result is in the output register. Reset
// clears the tables, avail_0..3, the scan state and the output valid flag.
module bankers_safety_checker_top
  import bsc_pkg::*;
#(
  parameter int CLIENTS     = DEF_CLIENTS,
  parameter int RESOURCES   = DEF_RESOURCES,
  parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [3:0] client, [11:4] amount_0, [19:12] amount_1, [27:20] amount_2,
  // [35:28] amount_3, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] func
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [2:0] seq_client, [7:3] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                   m_axis_tlast_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  cmd_t                               cmd;
  sts_t                               sts;
  logic [NUM_AVAIL-1:0][AVAIL_W-1:0]  avail;
  logic [NUM_AVAIL-1:0][AMT_IN_W-1:0] in_amt;
  status_e                            out_status;
  logic [SEQ_W-1:0]                   out_seq;

  always_comb begin
    for (int r = 0; r < NUM_AVAIL; r++) begin
      in_amt[r] = s_axis_tdata_i[CLIENT_W + AMT_IN_W*r +: AMT_IN_W];
    end
  end

  assign m_axis_tdata_o = OUT_TDATA_W'(out_seq);
  assign m_axis_tuser_o = OUT_TUSER_W'(out_status);

  bsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .avail_o (avail)
  );

  bsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsc_dp #(
    .CLIENTS     (CLIENTS),
    .RESOURCES   (RESOURCES),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_func_i    (s_axis_tuser_i),
    .in_client_i  (s_axis_tdata_i[CLIENT_W-1:0]),
    .in_amt_i     (in_amt),
    .avail_i      (avail),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_seq_o    (out_seq),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// ===== rtl/core/bsc_checker.sv =====
// Port-level assertions for the banker's safety checker, bound to the top level.
`include "assert_macros.svh"

module bsc_checker
  import bsc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  input logic                   m_axis_tlast_o,
  input logic                   pready
);

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o)))

  // The block works on one request at a time.
  `ASSERT_CLK(a_one_at_a_time, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)

  // Any result with a status other than OK stands alone with no client.
  `ASSERT_CLK(a_status_alone, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o != OUT_TUSER_W'(ST_OK)) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))

  // The configuration port never inserts wait states.
  `ASSERT_NEVER(a_pready_high, clk_i, rst_ni, !pready)

endmodule

bind bankers_safety_checker_top bsc_checker u_bsc_checker (.*);

// ===== bench/bankers_safety_checker_top_tb.sv =====
// Self-checking bench for the banker's safety checker: directed table, random commands, APB setup.
module bankers_safety_checker_top_tb;
  import bsc_pkg::*;

  localparam int DRAIN_CYCLES = 2 * DEF_CLIENTS * DEF_CLIENTS + 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 50;

  typedef struct packed {
    func_e            func;
    logic [3:0]       client;
    logic [3:0][7:0]  amt;
  } request_t;

  typedef struct packed {
    status_e          status;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } verdict_t;

  // A row with known set carries a single result that is obvious from the command.
  typedef struct packed {
    func_e       func;
    logic [3:0]  client;
    logic [31:0] amounts;
    logic        known;
    status_e     want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  logic [7:0] max_tab   [DEF_CLIENTS][DEF_RESOURCES];
  logic [7:0] alloc_tab [DEF_CLIENTS][DEF_RESOURCES];
  logic [7:0] avail_reg [NUM_AVAIL];
  verdict_t   verdict_q [$];
  int         mismatch_count = 0;
  bit         idle_on = 1'b1;

  stim_row_t directed_rows [23] = '{
    '{FUNC_RUN,      4'd0,  32'h0000_0000, 1'b0, ST_OK},
    '{FUNC_LOAD_MAX, 4'd15, 32'hffff_ffff, 1'b1, ST_BAD_CLIENT},
    '{FUNC_REQUEST,  4'd8,  32'hffff_ffff, 1'b1, ST_BAD_CLIENT},
    '{FUNC_RELEASE,  4'd9,  32'h0000_0000, 1'b1, ST_BAD_CLIENT},
    '{FUNC_RELEASE,  4'd0,  32'h0000_0001, 1'b1, ST_NO_RELEASE},
    '{FUNC_LOAD_MAX, 4'd0,  32'hffff_ffff, 1'b1, ST_OK},
    '{FUNC_RUN,      4'd15, 32'hffff_ffff, 1'b1, ST_UNSAFE},
    '{FUNC_REQUEST,  4'd0,  32'hffff_ffff, 1'b1, ST_OK},
    '{FUNC_RUN,      4'd0,  32'h0000_0000, 1'b0, ST_OK},
    '{FUNC_REQUEST,  4'd7,  32'hffff_ffff, 1'b1, ST_OK},
    '{FUNC_LOAD_MAX, 4'd7,  32'h0000_0000, 1'b1, ST_OK},
    '{FUNC_REQUEST,  4'd0,  32'h0000_0000, 1'b1, ST_OK},
    // Client 0 only fits once client 7, allocated above its maximum, hands back its units.
    '{FUNC_RUN,      4'd7,  32'h0000_0000, 1'b0, ST_OK},
    '{FUNC_RELEASE,  4'd7,  32'hff00_0000, 1'b1, ST_OK},
    '{FUNC_RELEASE,  4'd7,  32'h0100_0000, 1'b1, ST_NO_RELEASE},
    '{FUNC_RELEASE,  4'd7,  32'h00ff_ffff, 1'b1, ST_OK},
    '{FUNC_RUN,      4'd0,  32'h0000_0000, 1'b1, ST_UNSAFE},
    '{FUNC_LOAD_MAX, 4'd3,  32'h4030_2010, 1'b1, ST_OK},
    '{FUNC_REQUEST,  4'd3,  32'h0000_0010, 1'b1, ST_OK},
    '{FUNC_REQUEST,  4'd5,  32'haa55_aa55, 1'b1, ST_OK},
    '{FUNC_LOAD_MAX, 4'd5,  32'h55aa_55aa, 1'b1, ST_OK},
    '{FUNC_RUN,      4'd0,  32'h0000_0000, 1'b0, ST_OK},
    '{FUNC_RELEASE,  4'd5,  32'haa55_aa55, 1'b1, ST_OK}
  };

  bankers_safety_checker_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one accepted request to the shadow tables and queues the results it causes.
  function automatic void banker_predict(request_t req);
    logic [WORK_BITS-1:0] work [DEF_RESOURCES];
    bit                   done [DEF_CLIENTS];
    logic [SEQ_W-1:0]     order [DEF_CLIENTS];
    int                   count;
    int                   sum;
    int                   n;
    bit                   progress;
    bit                   fits;
    bit                   overdraw;
    if (req.func == FUNC_RUN) begin
      for (int r = 0; r < DEF_RESOURCES; r++) work[r] = WORK_BITS'(avail_reg[r]);
      for (int c = 0; c < DEF_CLIENTS; c++) done[c] = 1'b0;
      count = 0;
      progress = 1'b1;
      while (progress) begin
        progress = 1'b0;
        for (int c = 0; c < DEF_CLIENTS; c++) begin
          if (!done[c]) begin
            fits = 1'b1;
            // A negative need (allocation above maximum) always fits.
            for (int r = 0; r < DEF_RESOURCES; r++)
              if (int'(max_tab[c][r]) - int'(alloc_tab[c][r]) > int'(work[r])) fits = 1'b0;
            if (fits) begin
              for (int r = 0; r < DEF_RESOURCES; r++) begin
                sum = int'(work[r]) + int'(alloc_tab[c][r]);
                work[r] = (sum > WORK_MAX) ? WORK_BITS'(WORK_MAX) : WORK_BITS'(sum);
              end
              done[c] = 1'b1;
              order[count] = SEQ_W'(c);
              count++;
              progress = 1'b1;
            end
          end
        end
      end
      if (count < DEF_CLIENTS) begin
        verdict_q.push_back('{ST_UNSAFE, SEQ_W'(0), 1'b1});
      end else begin
        n = (DEF_CLIENTS < MAX_RESULTS) ? DEF_CLIENTS : MAX_RESULTS;
        for (int k = 0; k < n; k++) verdict_q.push_back('{ST_OK, order[k], k == n - 1});
      end
      return;
    end
    if (req.client >= DEF_CLIENTS) begin
      verdict_q.push_back('{ST_BAD_CLIENT, SEQ_W'(0), 1'b1});
      return;
    end
    case (req.func)
      FUNC_LOAD_MAX: begin
        for (int r = 0; r < DEF_RESOURCES; r++) max_tab[req.client][r] = req.amt[r];
      end
      FUNC_REQUEST: begin
        for (int r = 0; r < DEF_RESOURCES; r++) alloc_tab[req.client][r] = req.amt[r];
      end
      default: begin
        overdraw = 1'b0;
        for (int r = 0; r < DEF_RESOURCES; r++)
          if (req.amt[r] > alloc_tab[req.client][r]) overdraw = 1'b1;
        if (overdraw) begin
          verdict_q.push_back('{ST_NO_RELEASE, SEQ_W'(0), 1'b1});
          return;
        end
        for (int r = 0; r < DEF_RESOURCES; r++)
          alloc_tab[req.client][r] = alloc_tab[req.client][r] - req.amt[r];
      end
    endcase
    verdict_q.push_back('{ST_OK, SEQ_W'(0), 1'b1});
  endfunction

  // Mostly well-formed commands against the current tables, with some noise mixed in.
  function automatic request_t make_request();
    request_t req;
    int       pick;
    int       c;
    pick = $urandom_range(0, 99);
    c = $urandom_range(0, DEF_CLIENTS - 1);
    req.client = 4'(c);
    for (int r = 0; r < 4; r++) req.amt[r] = 8'($urandom);
    if (pick < 12) begin
      req.func = FUNC_RUN;
      req.client = 4'($urandom);
    end else if (pick < 32) begin
      req.func = FUNC_LOAD_MAX;
      if ($urandom_range(0, 1) == 0)
        for (int r = 0; r < 4; r++) req.amt[r] = 8'($urandom_range(0, 40));
    end else if (pick < 60) begin
      req.func = FUNC_REQUEST;
      if ($urandom_range(0, 7) != 0)
        for (int r = 0; r < 4; r++) req.amt[r] = 8'($urandom_range(0, max_tab[c][r]));
    end else if (pick < 82) begin
      req.func = FUNC_RELEASE;
      if ($urandom_range(0, 4) != 0)
        for (int r = 0; r < 4; r++) req.amt[r] = 8'($urandom_range(0, alloc_tab[c][r]));
    end else if (pick < 90) begin
      req.func = func_e'($urandom_range(0, 2));
      req.client = 4'($urandom_range(DEF_CLIENTS, 15));
    end else begin
      req.func = func_e'($urandom_range(0, 3));
      req.client = 4'($urandom);
    end
    return req;
  endfunction

  task automatic send_request(request_t req, bit known, status_e want);
    int depth;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, req.amt, req.client};
    s_tuser  <= req.func;
    do @(posedge clk); while (!s_tready);
    depth = verdict_q.size();
    banker_predict(req);
    if (known) begin
      while (verdict_q.size() > depth) void'(verdict_q.pop_back());
      verdict_q.push_back('{want, SEQ_W'(0), 1'b1});
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all available-unit registers, then reads each one back.
  task automatic program_avail(logic [3:0][7:0] vals);
    for (int readback = 0; readback < 2; readback++) begin
      for (int i = 0; i < NUM_AVAIL; i++) begin
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= (readback == 0);
        paddr   <= CFG_ADDR_W'(4 * i);
        pwdata  <= CFG_DATA_W'(vals[i]);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (readback == 0) begin
          avail_reg[i] = vals[i];
        end else if (prdata[AVAIL_W-1:0] !== avail_reg[i]) begin
          $error("avail_%0d: expected %0d, got %0d", i, avail_reg[i], prdata[AVAIL_W-1:0]);
          mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
      end
    end
  endtask

  initial begin : sink_pacing
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result: status %0d seq_client %0d last %0d",
               m_tuser[1:0], m_tdata[SEQ_W-1:0], m_tlast);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (m_tuser[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser[1:0]);
          mismatch_count++;
        end
        if (m_tdata[SEQ_W-1:0] !== want.seq) begin
          $error("seq_client: expected %0d, got %0d", want.seq, m_tdata[SEQ_W-1:0]);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    request_t        req;
    logic [3:0][7:0] vals;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    for (int c = 0; c < DEF_CLIENTS; c++)
      for (int r = 0; r < DEF_RESOURCES; r++) begin
        max_tab[c][r]   = '0;
        alloc_tab[c][r] = '0;
      end
    for (int i = 0; i < NUM_AVAIL; i++) avail_reg[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      req.func   = directed_rows[i].func;
      req.client = directed_rows[i].client;
      req.amt    = directed_rows[i].amounts;
      send_request(req, directed_rows[i].known, directed_rows[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       vals = '0;
        1:       vals = '1;
        default: vals = $urandom;
      endcase
      program_avail(vals);
      idle_on = (phase != PHASES - 1);
      repeat (PHASE_ITEMS) send_request(make_request(), 1'b0, ST_OK);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_regs.sv
rtl/core/bsc_ctrl.sv
rtl/core/bsc_dp.sv
rtl/core/bankers_safety_checker_top.sv
rtl/core/bsc_checker.sv
bench/bankers_safety_checker_top_tb.sv
